[rtl/core/assert_macros.svh]
// Assertion macros shared by the Fibonacci fast-doubling RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every rising clock edge outside reset.
`define FIBFD_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");

// Condition that must never be seen at a rising clock edge outside reset.
`define FIBFD_NEVER(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("forbidden condition seen");

`endif

[rtl/core/fibfd_pkg.sv]
// Package with constants and types for the Fibonacci fast-doubling pipeline.
`default_nettype none

package fibfd_pkg;

   localparam int INDEX_BITS_DEFAULT = 32;
   localparam int INDEX_WIDTH        = 32;
   localparam int VALUE_WIDTH        = 64;
   localparam int HALF_WIDTH         = VALUE_WIDTH / 2;

   // One request as it travels between the per-bit doubling steps.
   typedef struct packed {
      logic                   valid;
      logic [INDEX_WIDTH-1:0] index;
      logic [VALUE_WIDTH-1:0] a;
      logic [VALUE_WIDTH-1:0] b;
   } item_type;

endpackage

`default_nettype wire

[rtl/core/fibonacci_fast_doubling_top.sv]
// A request passes through the step pipeline and then the output register on its way to the response.
// Throughput: one request per cycle while req_stall is low; each index bit owns four pipeline stages.
// The request stall rises only when the output skid entry is occupied.
// Reset clears every valid bit and the skid state; data registers are not reset.
`default_nettype none

`include "assert_macros.svh"

module fibonacci_fast_doubling_top #(
   parameter int INDEX_BITS = fibfd_pkg::INDEX_BITS_DEFAULT
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic [fibfd_pkg::INDEX_WIDTH-1:0] req_index,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic [fibfd_pkg::VALUE_WIDTH-1:0]      rsp_fib_value
);

   localparam int VW = fibfd_pkg::VALUE_WIDTH;

   fibfd_pkg::item_type link [INDEX_BITS+1];
   logic                advance;

   assign req_stall = !advance;

   // The walk starts from the pair F(0), F(1).
   always_comb begin
      link[0].valid = req_valid;
      link[0].index = req_index;
      link[0].a     = '0;
      link[0].b     = VW'(1);
   end

   genvar g;
   generate
      for (g = 0; g < INDEX_BITS; g++) begin : g_step
         fibfd_step #(
            .BIT_POS (INDEX_BITS - 1 - g)
         ) u_step (
            .clock   (clock),
            .reset   (reset),
            .advance (advance),
            .item_i  (link[g]),
            .item_o  (link[g+1])
         );
      end
   endgenerate

   fibfd_skid u_skid (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (link[INDEX_BITS].valid),
      .in_value      (link[INDEX_BITS].a),
      .advance       (advance),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_fib_value (rsp_fib_value)
   );

   `FIBFD_NEVER(a_skid_needs_output, clock, reset, !advance && !rsp_valid)
   `FIBFD_ASSERT(a_skid_fills_on_stall, clock, reset,
                 $fell(advance) |-> $past(rsp_valid && rsp_stall))
   `FIBFD_ASSERT(a_tail_frozen, clock, reset,
                 !advance |=> $stable(link[INDEX_BITS]))

endmodule

`default_nettype wire

[rtl/core/fibfd_step.sv]
// One fast-doubling step for a single index bit, split over four register stages.
`default_nettype none

module fibfd_step #(
   parameter int BIT_POS = 0
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               advance,
   input  wire fibfd_pkg::item_type item_i,
   output fibfd_pkg::item_type     item_o
);

   localparam int VW = fibfd_pkg::VALUE_WIDTH;
   localparam int HW = fibfd_pkg::HALF_WIDTH;
   localparam int IW = fibfd_pkg::INDEX_WIDTH;

   typedef struct packed {
      logic          valid;
      logic [IW-1:0] index;
      logic [VW-1:0] x;
      logic [VW-1:0] y;
      logic [VW-1:0] t;
   } sub_type;

   typedef struct packed {
      logic          valid;
      logic [IW-1:0] index;
      logic [VW-1:0] d_low;
      logic [HW-1:0] d_cross;
      logic [VW-1:0] xx_low;
      logic [HW-1:0] xx_cross;
      logic [VW-1:0] yy_low;
      logic [HW-1:0] yy_cross;
   } prod_type;

   typedef struct packed {
      logic          valid;
      logic [IW-1:0] index;
      logic [VW-1:0] d;
      logic [VW-1:0] s;
   } sum_type;

   sub_type             s1_ff, s1_in;
   prod_type            s2_ff, s2_in;
   sum_type             s3_ff, s3_in;
   fibfd_pkg::item_type s4_ff, s4_in;
   logic                bit_set;

   generate
      if (BIT_POS < IW) begin : g_bit
         assign bit_set = s3_ff.index[BIT_POS];
      end else begin : g_zero
         // Bits above the index field read as zero.
         assign bit_set = 1'b0;
      end
   endgenerate

   always_comb begin
      s1_in.valid = item_i.valid;
      s1_in.index = item_i.index;
      s1_in.x     = item_i.a;
      s1_in.y     = item_i.b;
      s1_in.t     = (item_i.b << 1) - item_i.a;
   end

   // Products modulo 2^64: the full low-by-low product plus the low halves of the
   // cross products shifted up by 32; the high-by-high product falls away entirely.
   always_comb begin
      s2_in.valid    = s1_ff.valid;
      s2_in.index    = s1_ff.index;
      s2_in.d_low    = VW'(s1_ff.x[HW-1:0]) * VW'(s1_ff.t[HW-1:0]);
      s2_in.d_cross  = HW'(s1_ff.x[HW-1:0] * s1_ff.t[VW-1:HW])
                     + HW'(s1_ff.x[VW-1:HW] * s1_ff.t[HW-1:0]);
      s2_in.xx_low   = VW'(s1_ff.x[HW-1:0]) * VW'(s1_ff.x[HW-1:0]);
      s2_in.xx_cross = HW'(s1_ff.x[HW-1:0] * s1_ff.x[VW-1:HW]) << 1;
      s2_in.yy_low   = VW'(s1_ff.y[HW-1:0]) * VW'(s1_ff.y[HW-1:0]);
      s2_in.yy_cross = HW'(s1_ff.y[HW-1:0] * s1_ff.y[VW-1:HW]) << 1;
   end

   always_comb begin
      s3_in.valid = s2_ff.valid;
      s3_in.index = s2_ff.index;
      s3_in.d     = s2_ff.d_low + {s2_ff.d_cross, {HW{1'b0}}};
      s3_in.s     = s2_ff.xx_low + s2_ff.yy_low
                  + {HW'(s2_ff.xx_cross + s2_ff.yy_cross), {HW{1'b0}}};
   end

   always_comb begin
      s4_in.valid = s3_ff.valid;
      s4_in.index = s3_ff.index;
      if (bit_set) begin
         s4_in.a = s3_ff.s;
         s4_in.b = s3_ff.d + s3_ff.s;
      end else begin
         s4_in.a = s3_ff.d;
         s4_in.b = s3_ff.s;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff.valid <= 1'b0;
         s2_ff.valid <= 1'b0;
         s3_ff.valid <= 1'b0;
         s4_ff.valid <= 1'b0;
      end else if (advance) begin
         s1_ff <= s1_in;
         s2_ff <= s2_in;
         s3_ff <= s3_in;
         s4_ff <= s4_in;
      end
   end

   assign item_o = s4_ff;

endmodule

`default_nettype wire

[rtl/core/fibfd_skid.sv]
// Output register with a skid entry that decouples the pipeline from the response stall.
`default_nettype none

module fibfd_skid (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              in_valid,
   input  wire logic [fibfd_pkg::VALUE_WIDTH-1:0] in_value,
   output logic                                   advance,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic [fibfd_pkg::VALUE_WIDTH-1:0]      rsp_fib_value
);

   localparam int VW = fibfd_pkg::VALUE_WIDTH;

   logic          out_valid_ff;
   logic [VW-1:0] out_value_ff;
   logic          skid_full_ff;
   logic [VW-1:0] skid_value_ff;
   logic          take;

   // The pipeline moves only while the skid entry is free, so a request leaving
   // the last stage always has somewhere to go.
   assign advance = !skid_full_ff;
   assign take    = advance && in_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         skid_full_ff <= 1'b0;
      end else if (!out_valid_ff || !rsp_stall) begin
         if (skid_full_ff) begin
            out_valid_ff <= 1'b1;
            out_value_ff <= skid_value_ff;
            skid_full_ff <= 1'b0;
         end else begin
            out_valid_ff <= take;
            out_value_ff <= in_value;
         end
      end else if (take) begin
         skid_full_ff  <= 1'b1;
         skid_value_ff <= in_value;
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_fib_value = out_value_ff;

endmodule

`default_nettype wire
